// File: hdl/ltec_pkg.sv
// Package for the LRU timestamp entry cache.
// Holds the sizes, status codes and payload types shared by ltec_scan, the top level and the testbench.
package ltec_pkg;

    localparam int ENTRY_DEPTH      = 1024;
    localparam int ENTRY_IDX_W      = $clog2(ENTRY_DEPTH);
    localparam int COUNT_W          = ENTRY_IDX_W + 1;
    localparam int FRAMES_PER_SHEET = 16;
    localparam int FRAME_W          = 4;
    localparam int STAMP_WIDTH      = 32;
    localparam int CFG_DATA_W       = 11;
    localparam int CFG_INDEX_W      = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROSTER_COUNT   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CACHE_CAPACITY = 1'b1;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(8);

    localparam logic [2:0] STATUS_DEFINED = 3'd0;
    localparam logic [2:0] STATUS_RANGE   = 3'd1;
    localparam logic [2:0] STATUS_HIT     = 3'd2;
    localparam logic [2:0] STATUS_LOADED  = 3'd3;
    localparam logic [2:0] STATUS_FAILED  = 3'd4;
    localparam logic [2:0] STATUS_NOSRC   = 3'd5;

    typedef struct packed {
        logic                   command;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic signed [7:0]      frame_request;
        logic                   is_sheet;
        logic                   has_source;
        logic                   load_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0]             status;
        logic [FRAME_W-1:0]     frame_index;
        logic                   evicted_valid;
        logic [ENTRY_IDX_W-1:0] evicted_index;
    } t_out_item;

    typedef struct packed {
        logic                   resident;
        logic                   failed;
        logic                   sheet;
        logic                   source;
        logic [STAMP_WIDTH-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic                   start;
        logic                   sample;
        logic [ENTRY_IDX_W-1:0] index;
    } t_scan_ctl;

    typedef struct packed {
        logic                   found;
        logic [ENTRY_IDX_W-1:0] index;
        t_entry                 entry;
    } t_scan_res;

endpackage

// File: hdl/ltec_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module ltec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ltec_scan.sv
// Oldest-entry search unit: one stamp compare per sampled entry.
// Depends on ltec_pkg for the entry and scan control types.
module ltec_scan
    import ltec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_ctl i_ctl,
    input  t_entry    i_entry,
    output t_scan_res o_res
);

    logic                   r_found;
    logic [ENTRY_IDX_W-1:0] r_index;
    t_entry                 r_entry;
    logic                   take;

    assign take = i_ctl.sample && i_entry.resident && i_entry.source &&
                  (!r_found || (i_entry.stamp < r_entry.stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_index <= i_ctl.index;
            r_entry <= i_entry;
        end
    end

    assign o_res.found = r_found;
    assign o_res.index = r_index;
    assign o_res.entry = r_entry;

endmodule

// File: hdl/lru_timestamp_entry_cache.sv
// Top level of the LRU timestamp entry cache: sequencer, entry table and counters.
// Depends on ltec_pkg, ltec_ram and ltec_scan.
//
// After reset the block clears every entry of the entry table and accepts no
// transaction until that pass is done; configuration writes are taken throughout.
// A define, a hit, an out-of-range access or an access that cannot load goes from the
// decision step straight to the done step; a load without eviction passes the check and
// load steps first. Each eviction adds a scan of the first min(roster_count, 1024)
// entries of the dual-port entry table at one entry per cycle. A miss that finds the
// resident count above the capacity repeats the scan for every eviction it needs.
// One transaction is worked on at a time; a new one is accepted while the previous
// result still waits in the output register.
module lru_timestamp_entry_cache
    import ltec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DECIDE    = 4'd2;
    localparam logic [3:0] S_CHECK     = 4'd3;
    localparam logic [3:0] S_SCAN      = 4'd4;
    localparam logic [3:0] S_SCAN_LAST = 4'd5;
    localparam logic [3:0] S_EVICT     = 4'd6;
    localparam logic [3:0] S_LOAD      = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    logic [3:0]             r_state,     n_state;
    logic [ENTRY_IDX_W-1:0] r_clr_addr,  n_clr_addr;
    logic [ENTRY_IDX_W-1:0] r_scan_addr, n_scan_addr;
    logic                   r_pend;
    logic [ENTRY_IDX_W-1:0] r_pend_addr;
    logic [COUNT_W-1:0]     r_roster;
    logic [COUNT_W-1:0]     r_capacity;
    logic [COUNT_W-1:0]     r_count,     n_count;
    logic [STAMP_WIDTH-1:0] r_clock,     n_clock;
    t_in_item               r_item,      n_item;
    t_out_item              r_res,       n_res;
    t_entry                 r_entry,     n_entry;
    t_out_item              r_out,       n_out;
    logic                   r_out_valid, n_out_valid;

    logic                   ram_we;
    logic [ENTRY_IDX_W-1:0] ram_waddr;
    t_entry                 ram_wdata;
    logic [ENTRY_IDX_W-1:0] ram_raddr;
    t_entry                 ram_rdata;
    t_scan_ctl              scan_ctl;
    t_scan_res              scan_res;
    logic [COUNT_W-1:0]     lim;
    logic [STAMP_WIDTH-1:0] clock_inc;
    logic [FRAME_W-1:0]     frame;

    ltec_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRY_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ltec_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_entry (ram_rdata),
        .o_res   (scan_res)
    );

    assign lim       = (r_roster > COUNT_W'(ENTRY_DEPTH)) ? COUNT_W'(ENTRY_DEPTH) : r_roster;
    assign clock_inc = r_clock + 1'b1;

    always_comb begin
        if (r_item.frame_request[7] || !ram_rdata.sheet) begin
            frame = '0;
        end else if (r_item.frame_request >= 8'(FRAMES_PER_SHEET)) begin
            frame = FRAME_W'(FRAMES_PER_SHEET - 1);
        end else begin
            frame = r_item.frame_request[FRAME_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_scan_addr = r_scan_addr;
        n_count     = r_count;
        n_clock     = r_clock;
        n_item      = r_item;
        n_res       = r_res;
        n_entry     = r_entry;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_item.entry_index;
        ram_wdata   = r_entry;
        ram_raddr   = r_scan_addr;
        scan_ctl    = '0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ENTRY_IDX_W'(ENTRY_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = i_in_data.entry_index;
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_res   = '0;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_entry = ram_rdata;
                n_state = S_DONE;
                if (!r_item.command) begin
                    ram_we           = 1'b1;
                    ram_wdata        = ram_rdata;
                    ram_wdata.sheet  = r_item.is_sheet;
                    ram_wdata.source = r_item.has_source;
                    n_res.status     = STATUS_DEFINED;
                end else if ({1'b0, r_item.entry_index} >= lim) begin
                    n_res.status = STATUS_RANGE;
                end else begin
                    n_res.frame_index = frame;
                    if (ram_rdata.resident) begin
                        ram_we          = 1'b1;
                        ram_wdata       = ram_rdata;
                        ram_wdata.stamp = clock_inc;
                        n_clock         = clock_inc;
                        n_res.status    = STATUS_HIT;
                    end else if (ram_rdata.failed) begin
                        n_res.status = STATUS_FAILED;
                    end else if (!ram_rdata.source) begin
                        n_res.status = STATUS_NOSRC;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if ((r_count >= r_capacity) && (lim != '0)) begin
                    scan_ctl.start = 1'b1;
                    n_scan_addr    = '0;
                    n_state        = S_SCAN;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_SCAN: begin
                ram_raddr       = r_scan_addr;
                scan_ctl.sample = r_pend;
                scan_ctl.index  = r_pend_addr;
                if ({1'b0, r_scan_addr} == (lim - 1'b1)) begin
                    n_state = S_SCAN_LAST;
                end else begin
                    n_scan_addr = r_scan_addr + 1'b1;
                end
            end
            S_SCAN_LAST: begin
                scan_ctl.sample = r_pend;
                scan_ctl.index  = r_pend_addr;
                n_state         = S_EVICT;
            end
            S_EVICT: begin
                if (scan_res.found) begin
                    ram_we             = 1'b1;
                    ram_waddr          = scan_res.index;
                    ram_wdata          = scan_res.entry;
                    ram_wdata.resident = 1'b0;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_res.evicted_valid = 1'b1;
                    n_res.evicted_index = scan_res.index;
                    n_state             = S_CHECK;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                ram_we    = 1'b1;
                ram_wdata = r_entry;
                if (r_item.load_ok) begin
                    ram_wdata.resident = 1'b1;
                    ram_wdata.stamp    = clock_inc;
                    n_clock            = clock_inc;
                    n_count            = r_count + 1'b1;
                    n_res.status       = STATUS_LOADED;
                end else begin
                    ram_wdata.failed = 1'b1;
                    n_res.status     = STATUS_FAILED;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_roster    <= '0;
            r_capacity  <= CAPACITY_RESET;
            r_count     <= '0;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_pend      <= (r_state == S_SCAN);
            r_count     <= n_count;
            r_clock     <= n_clock;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROSTER_COUNT:   r_roster   <= i_cfg_data;
                    CFG_CACHE_CAPACITY: r_capacity <= i_cfg_data;
                    default:            r_roster   <= r_roster;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_addr <= n_scan_addr;
        r_pend_addr <= r_scan_addr;
        r_item      <= n_item;
        r_res       <= n_res;
        r_entry     <= n_entry;
        r_out       <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(ENTRY_DEPTH))
        else $error("resident count above table depth");

    a_accept_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECIDE))
        else $error("accepted transaction did not reach the decision step");

    a_evict_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT && scan_res.found && r_count != '0)
            |=> (r_count == $past(r_count) - 1'b1))
        else $error("eviction did not decrement the resident count");

    a_evict_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.evicted_valid)
            |-> (o_out_data.status == STATUS_LOADED || o_out_data.status == STATUS_FAILED))
        else $error("eviction reported on a transaction without a load");

    a_scan_in_roster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_scan_addr} < lim))
        else $error("scan address beyond the roster");

endmodule

// File: tb/sv/lru_timestamp_entry_cache_tb.sv
// Self-checking testbench for the LRU timestamp entry cache.
// Depends on ltec_pkg and lru_timestamp_entry_cache; predicts each reply from its own
// copy of the entry table and checks every output transaction against it.
module lru_timestamp_entry_cache_tb
    import ltec_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;

    localparam logic CMD_DEFINE = 1'b0;
    localparam logic CMD_ACCESS = 1'b1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_item              o_out_data;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    t_in_item  request_backlog[$];
    t_out_item reply_due[$];
    t_out_item reply_head;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int error_count = 0;
    int cycle_count = 0;

    // Shadow copy of the cache state and its configuration.
    int                     roster_cfg = 0;
    int                     capacity_cfg = int'(CAPACITY_RESET);
    bit                     resident_map[ENTRY_DEPTH];
    bit                     failed_map[ENTRY_DEPTH];
    bit                     sheet_map[ENTRY_DEPTH];
    bit                     source_map[ENTRY_DEPTH];
    logic [STAMP_WIDTH-1:0] stamp_map[ENTRY_DEPTH];
    logic [STAMP_WIDTH-1:0] use_tick = '0;
    int                     resident_total = 0;

    lru_timestamp_entry_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_out_item cache_reply(t_in_item it);
        t_out_item              r;
        int                     idx;
        int                     lim;
        int                     req;
        int                     f;
        int                     victim;
        int                     i;
        bit                     found;
        logic [STAMP_WIDTH-1:0] oldest;
        r = '0;
        idx = int'(it.entry_index);
        lim = (roster_cfg > ENTRY_DEPTH) ? ENTRY_DEPTH : roster_cfg;
        if (it.command == CMD_DEFINE) begin
            r.status = STATUS_DEFINED;
            sheet_map[idx] = it.is_sheet;
            source_map[idx] = it.has_source;
        end else if (idx >= lim) begin
            r.status = STATUS_RANGE;
        end else begin
            req = int'(it.frame_request);
            f = (req < 0) ? 0 : req;
            if (f >= (sheet_map[idx] ? FRAMES_PER_SHEET : 1)) begin
                f = sheet_map[idx] ? FRAMES_PER_SHEET - 1 : 0;
            end
            r.frame_index = FRAME_W'(f);
            if (resident_map[idx]) begin
                use_tick = use_tick + 1'b1;
                stamp_map[idx] = use_tick;
                r.status = STATUS_HIT;
            end else if (failed_map[idx]) begin
                r.status = STATUS_FAILED;
            end else if (!source_map[idx]) begin
                r.status = STATUS_NOSRC;
            end else begin
                while (resident_total >= capacity_cfg) begin
                    found = 1'b0;
                    victim = 0;
                    oldest = '0;
                    for (i = 0; i < lim; i++) begin
                        if (resident_map[i] && source_map[i]
                            && (!found || stamp_map[i] < oldest)) begin
                            found = 1'b1;
                            oldest = stamp_map[i];
                            victim = i;
                        end
                    end
                    if (!found) begin
                        break;
                    end
                    resident_map[victim] = 1'b0;
                    if (resident_total > 0) begin
                        resident_total--;
                    end
                    r.evicted_valid = 1'b1;
                    r.evicted_index = ENTRY_IDX_W'(victim);
                end
                if (it.load_ok) begin
                    resident_map[idx] = 1'b1;
                    use_tick = use_tick + 1'b1;
                    stamp_map[idx] = use_tick;
                    resident_total++;
                    r.status = STATUS_LOADED;
                end else begin
                    failed_map[idx] = 1'b1;
                    r.status = STATUS_FAILED;
                end
            end
        end
        return r;
    endfunction

    function automatic t_in_item define_req(int idx, bit sheet, bit src);
        t_in_item it;
        it = '0;
        it.command = CMD_DEFINE;
        it.entry_index = ENTRY_IDX_W'(idx);
        it.is_sheet = sheet;
        it.has_source = src;
        it.frame_request = 8'($urandom);
        it.load_ok = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_in_item access_req(int idx, int frame, bit ok);
        t_in_item it;
        it = '0;
        it.command = CMD_ACCESS;
        it.entry_index = ENTRY_IDX_W'(idx);
        it.frame_request = 8'(frame);
        it.load_ok = ok;
        it.is_sheet = 1'($urandom_range(1));
        it.has_source = 1'($urandom_range(1));
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                reply_due.push_back(cache_reply(i_in_data));
            end
            if (!i_in_valid || o_in_ready) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_data <= request_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (reply_due.size() == 0) begin
                    $display("%0t: unexpected reply status %0d frame %0d evict %0b/%0d", $time,
                             o_out_data.status, o_out_data.frame_index,
                             o_out_data.evicted_valid, o_out_data.evicted_index);
                    error_count++;
                end else begin
                    reply_head = reply_due.pop_front();
                    if (o_out_data.status !== reply_head.status
                        || o_out_data.frame_index !== reply_head.frame_index
                        || o_out_data.evicted_valid !== reply_head.evicted_valid
                        || o_out_data.evicted_index !== reply_head.evicted_index) begin
                        $display({"%0t: expected status %0d frame %0d evict %0b/%0d, ",
                                  "got status %0d frame %0d evict %0b/%0d"},
                                 $time, reply_head.status, reply_head.frame_index,
                                 reply_head.evicted_valid, reply_head.evicted_index,
                                 o_out_data.status, o_out_data.frame_index,
                                 o_out_data.evicted_valid, o_out_data.evicted_index);
                        error_count++;
                    end
                end
            end
            if (hold_served != hold_requests) begin
                hold_served <= hold_requests;
                hold_left <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[lru_timestamp_entry_cache] ERROR");
            $finish;
        end
    end

    task automatic drain_all();
        do begin
            @(negedge i_clk);
        end while (request_backlog.size() != 0 || i_in_valid || reply_due.size() != 0);
    endtask

    task automatic set_registers(int roster, int capacity);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_ROSTER_COUNT;
        i_cfg_data <= CFG_DATA_W'(roster);
        roster_cfg = roster & 'h7ff;
        @(posedge i_clk);
        i_cfg_index <= CFG_CACHE_CAPACITY;
        i_cfg_data <= CFG_DATA_W'(capacity);
        capacity_cfg = capacity & 'h7ff;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_random(int n, int span);
        int k;
        int roll;
        int frame;
        int lead;
        lead = (span < 16) ? span : 16;
        for (k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            frame = $urandom_range(1) ? $urandom_range(17) : $urandom;
            if (k < lead) begin
                request_backlog.push_back(define_req(span <= 16 ? k : $urandom_range(span - 1),
                                                     1'($urandom_range(1)),
                                                     $urandom_range(9) != 0));
            end else if (roll < 15) begin
                request_backlog.push_back(define_req($urandom_range(span - 1),
                                                     1'($urandom_range(1)),
                                                     $urandom_range(9) != 0));
            end else if (roll < 20) begin
                request_backlog.push_back(access_req($urandom_range(ENTRY_DEPTH - 1), frame,
                                                     1'($urandom_range(1))));
            end else begin
                request_backlog.push_back(access_req($urandom_range(span - 1), frame,
                                                     $urandom_range(7) != 0));
            end
        end
    endtask

    task automatic run_phase(int roster, int capacity, int s_idle, int r_stall, int n,
                             int span, bit long_hold, bit mid_pause);
        drain_all();
        set_registers(roster, capacity);
        sender_idle_pct = s_idle;
        receiver_stall_pct = r_stall;
        if (mid_pause) begin
            queue_random(n / 2, span);
            drain_all();
            queue_random(n - n / 2, span);
        end else begin
            queue_random(n, span);
        end
        if (long_hold) begin
            hold_requests++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // With the reset roster of zero every access is out of range.
        request_backlog.push_back(access_req(0, 0, 1'b1));
        request_backlog.push_back(define_req(0, 1'b1, 1'b1));
        request_backlog.push_back(access_req(0, 3, 1'b1));
        drain_all();
        set_registers(16, 2);
        request_backlog.push_back(define_req(1, 1'b0, 1'b1));
        request_backlog.push_back(define_req(2, 1'b1, 1'b1));
        request_backlog.push_back(define_req(3, 1'b1, 1'b0));
        request_backlog.push_back(define_req(4, 1'b0, 1'b1));
        request_backlog.push_back(define_req(1023, 1'b1, 1'b1));
        request_backlog.push_back(access_req(0, 127, 1'b1));
        request_backlog.push_back(access_req(1, -128, 1'b1));
        request_backlog.push_back(access_req(0, -1, 1'b1));
        request_backlog.push_back(access_req(2, 16, 1'b1));
        request_backlog.push_back(access_req(1, 1, 1'b1));
        request_backlog.push_back(access_req(2, 15, 1'b1));
        request_backlog.push_back(access_req(3, 5, 1'b1));
        request_backlog.push_back(access_req(4, 0, 1'b0));
        request_backlog.push_back(access_req(4, 0, 1'b1));
        request_backlog.push_back(access_req(16, 0, 1'b1));
        request_backlog.push_back(access_req(1023, 0, 1'b1));
        // Redefining resident entries without a source leaves nothing to evict.
        request_backlog.push_back(define_req(2, 1'b0, 1'b0));
        request_backlog.push_back(access_req(2, 7, 1'b1));
        request_backlog.push_back(define_req(1, 1'b0, 1'b0));
        request_backlog.push_back(define_req(0, 1'b0, 1'b0));
        request_backlog.push_back(define_req(5, 1'b1, 1'b1));
        request_backlog.push_back(access_req(5, 8, 1'b1));

        run_phase(24, 8, 0, 0, 100, 24, 1'b0, 1'b0);
        run_phase(24, 3, 48, 0, 80, 24, 1'b0, 1'b0);
        run_phase(40, 1, 0, 48, 80, 40, 1'b1, 1'b0);
        run_phase(12, 0, 36, 36, 50, 12, 1'b0, 1'b0);
        run_phase(1024, 1024, 0, 0, 40, 1024, 1'b0, 1'b0);
        run_phase(1500, 4, 0, 0, 30, 32, 1'b0, 1'b0);
        run_phase(0, 8, 0, 0, 20, 16, 1'b0, 1'b0);
        run_phase(64, 6, 36, 36, 100, 64, 1'b0, 1'b1);

        drain_all();
        repeat (16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[lru_timestamp_entry_cache] OK");
        end else begin
            $display("[lru_timestamp_entry_cache] ERROR");
        end
        $finish;
    end

endmodule
